// ----- src/sdec_pkg.sv -----
// Shared constants, types and helper functions for the decimal text converter.
package sdec_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CHAR_W     = 7;
    localparam int LEN_W      = 4;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int MAX_LEN    = NUM_DIGITS + 1;

    localparam logic [CHAR_W-1:0]  MINUS_CODE = 7'd45;
    localparam logic [CHAR_W-1:0]  ZERO_CODE  = 7'd48;
    localparam logic [CHAR_W-1:0]  NINE_CODE  = 7'd57;
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

    typedef struct packed {
        logic               start;
        logic               negative;
        logic [VALUE_W-1:0] magnitude;
    } sdec_start_t;

    typedef struct packed {
        logic             done;
        logic             negative;
        logic [BCD_W-1:0] bcd;
    } sdec_bcd_t;

    function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0]   res;
        logic [DIGIT_W-1:0] d;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd[i*DIGIT_W +: DIGIT_W];
            if (d >= ADJ_LIMIT)
            begin
                res[i*DIGIT_W +: DIGIT_W] = d + ADJ_ADD;
            end
        end
        return res;
    endfunction

    function automatic logic [DIGIT_W-1:0] pick_digit(input logic [BCD_W-1:0] bcd,
                                                      input logic [IDX_W-1:0] idx);
        logic [DIGIT_W-1:0] d;
        d = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (idx == IDX_W'(i))
            begin
                d = bcd[i*DIGIT_W +: DIGIT_W];
            end
        end
        return d;
    endfunction

endpackage

// ----- src/sdec_if.sv -----
// Handshake channel interfaces for the integer input and the character output.
interface sdec_num_if;
    import sdec_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface sdec_char_if;
    import sdec_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
    logic [LEN_W-1:0]  text_length;

    modport source (output valid, output char_code, output is_last, output text_length,
                    input ready);
    modport sink (input valid, input char_code, input is_last, input text_length,
                  output ready);
endinterface

// ----- src/sdec_dabble.sv -----
// Iterative shift-and-add-3 unit that turns a 32-bit magnitude into ten BCD digits.
module sdec_dabble (
    input  logic                clk,
    input  logic                rst_n,
    input  sdec_pkg::sdec_start_t cmd,
    output sdec_pkg::sdec_bcd_t   res
);
    import sdec_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   adj;

    always_comb
    begin
        adj       = dabble_adjust(bcd_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = cmd.negative;
            bin_next  = cmd.magnitude;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign res.done     = done_reg;
    assign res.negative = neg_reg;
    assign res.bcd      = bcd_reg;

endmodule

// ----- src/sdec_emit.sv -----
// Character sequencer: sign, then digits without leading zeros, through an output register.
module sdec_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  sdec_pkg::sdec_bcd_t res,
    sdec_char_if.source         chars,
    output logic                done
);
    import sdec_pkg::*;

    logic              valid_reg, valid_next;
    logic              more_reg, more_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [IDX_W-1:0]  ndig;
    logic [LEN_W-1:0]  total;
    logic [DIGIT_W-1:0] lead;
    logic [DIGIT_W-1:0] cur;

    always_comb
    begin
        ndig = IDX_W'(1);
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (res.bcd[i*DIGIT_W +: DIGIT_W] != '0)
            begin
                ndig = IDX_W'(i + 1);
            end
        end
    end

    assign total = LEN_W'(ndig) + LEN_W'(res.negative);
    assign lead  = pick_digit(res.bcd, ndig - 1'b1);
    assign cur   = pick_digit(bcd_reg, idx_reg);

    always_comb
    begin
        valid_next = valid_reg;
        more_next  = more_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        bcd_next   = bcd_reg;
        done       = 1'b0;
        if (res.done)
        begin
            valid_next = 1'b1;
            bcd_next   = res.bcd;
            len_next   = total;
            if (res.negative)
            begin
                char_next = MINUS_CODE;
                last_next = 1'b0;
                more_next = 1'b1;
                idx_next  = ndig - 1'b1;
            end
            else
            begin
                char_next = ZERO_CODE + CHAR_W'(lead);
                last_next = (ndig == IDX_W'(1));
                more_next = (ndig != IDX_W'(1));
                idx_next  = ndig - IDX_W'(2);
            end
        end
        else if (valid_reg && chars.ready)
        begin
            done = last_reg;
            if (more_reg)
            begin
                char_next = ZERO_CODE + CHAR_W'(cur);
                last_next = (idx_reg == '0);
                more_next = (idx_reg != '0);
                idx_next  = idx_reg - 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
                more_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            more_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            more_reg  <= more_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        len_reg  <= len_next;
        bcd_reg  <= bcd_next;
    end

    assign chars.valid       = valid_reg;
    assign chars.char_code   = char_reg;
    assign chars.is_last     = last_reg;
    assign chars.text_length = len_reg;

endmodule

// ----- src/signed_int_to_decimal_ascii_unit.sv -----
// Signed 32-bit integer to decimal ASCII text: one accepted integer yields 1 to 11
// character beats, a minus sign first for negative values, then the digits most
// significant first with no leading zeros; every beat carries is_last and the total
// text_length. The integer port takes one value and then stays not ready until the
// last character beat of that value has been taken. Conversion runs a shift-and-add-3
// loop, one input bit per cycle, and then a character sequencer emits the digits.
module signed_int_to_decimal_ascii_unit (
    input  logic        clk,
    input  logic        rst_n,
    sdec_num_if.sink    num,
    sdec_char_if.source chars
);
    import sdec_pkg::*;

    typedef enum logic {ST_IDLE, ST_BUSY} state_t;

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] raw;
    logic               accept;
    logic               emit_done;
    sdec_start_t        cmd;
    sdec_bcd_t          res;

    assign raw       = num.value;
    assign num.ready = (state_reg == ST_IDLE);
    assign accept    = num.valid && num.ready;

    assign cmd.start     = accept;
    assign cmd.negative  = raw[VALUE_W-1];
    assign cmd.magnitude = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    sdec_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    sdec_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .chars (chars),
        .done  (emit_done)
    );

endmodule

// ----- src/sdec_checker.sv -----
// Port-level assertions for the decimal text converter, bound to the top level.
module sdec_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [sdec_pkg::CHAR_W-1:0] char_code,
    input logic                        is_last,
    input logic [sdec_pkg::LEN_W-1:0]  text_length
);
    import sdec_pkg::*;

    a_no_take_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a character beat is pending");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after taking a value");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !is_last) |=> out_valid)
        else $error("character run broken before its last beat");

    a_legal_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((char_code == MINUS_CODE ||
                        (char_code >= ZERO_CODE && char_code <= NINE_CODE)) &&
                       text_length >= LEN_W'(1) && text_length <= LEN_W'(MAX_LEN)))
        else $error("illegal character or length");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(char_code) &&
                                       $stable(is_last) && $stable(text_length)))
        else $error("stalled character beat changed");

endmodule

bind signed_int_to_decimal_ascii_unit sdec_checker u_sdec_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (num.valid),
    .in_ready    (num.ready),
    .out_valid   (chars.valid),
    .out_ready   (chars.ready),
    .char_code   (chars.char_code),
    .is_last     (chars.is_last),
    .text_length (chars.text_length)
);
